### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FFL_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ffl assertion failed");

// Concurrent assertion on clk_i and rst_ni of the enclosing scope.
`define FFL_ASSERT(lbl, prop) \
  `FFL_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`endif

### rtl/core/ffl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffl_pkg;

  localparam int unsigned OpW        = 2;
  localparam int unsigned IdW        = 8;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned AllocIdW   = 7;
  localparam int unsigned FreeLeftW  = 8;
  // Only IDs that fit the id field can ever be released or checked.
  localparam int unsigned MapMaxDepth = 2 ** IdW;

  typedef enum logic [OpW-1:0] {
    OpAlloc   = 2'd0,
    OpRelease = 2'd1,
    OpCheck   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StRange    = 2'd2,
    StNotAlloc = 2'd3
  } status_e;

  typedef struct packed {
    logic           pop;
    logic           push;
    logic [IdW-1:0] push_id;
  } ring_ctl_t;

  typedef struct packed {
    logic           set;
    logic [IdW-1:0] set_id;
    logic           clr;
    logic [IdW-1:0] clr_id;
  } map_upd_t;

endpackage

`default_nettype wire

### rtl/core/ffl_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffl_req_if;
  logic                        valid;
  logic                        ready;
  logic [ffl_pkg::OpW-1:0]     op;
  logic [ffl_pkg::IdW-1:0]     id;

  modport source (output valid, output op, output id, input ready);
  modport sink   (input valid, input op, input id, output ready);
endinterface

`default_nettype wire

### rtl/core/ffl_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ffl_pkg::StatusW-1:0]     status;
  logic [ffl_pkg::AllocIdW-1:0]    alloc_id;
  logic                            id_free;
  logic [ffl_pkg::FreeLeftW-1:0]   free_left;

  modport source (output valid, output status, output alloc_id, output id_free,
                  output free_left, input ready);
  modport sink   (input valid, input status, input alloc_id, input id_free,
                  input free_left, output ready);
endinterface

`default_nettype wire

### rtl/core/ffl_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module ffl_ring #(
  parameter int unsigned NUM_IDS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffl_pkg::ring_ctl_t            ctl_i,
  output logic [$clog2(NUM_IDS)-1:0]    head_val_o
);

  localparam int unsigned IdxW = $clog2(NUM_IDS);
  localparam int unsigned CntW = $clog2(NUM_IDS + 1);

  localparam logic [1:0] SrcIdx = 2'd0;
  localparam logic [1:0] SrcMem = 2'd1;
  localparam logic [1:0] SrcByp = 2'd2;

  logic [IdxW-1:0] mem [NUM_IDS];
  logic [IdxW-1:0] mem_rd_q;
  logic [IdxW-1:0] byp_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [1:0]      src_q, src_d;
  logic [IdxW-1:0] wr_data;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] p);
    ring_next = (p == IdxW'(NUM_IDS - 1)) ? '0 : p + IdxW'(1);
  endfunction

  assign wr_data = IdxW'(ctl_i.push_id);
  assign head_d  = ctl_i.pop  ? ring_next(head_q) : head_q;
  assign tail_d  = ctl_i.push ? ring_next(tail_q) : tail_q;

  // Pushes land in ascending slots from zero, so slots below fill hold written data.
  always_comb begin
    fill_d = fill_q;
    if (ctl_i.push && (fill_q != CntW'(NUM_IDS))) begin
      fill_d = fill_q + CntW'(1);
    end
    if (ctl_i.push && (tail_d == head_d)) begin
      src_d = SrcByp;
    end else if (CntW'(head_d) < fill_q) begin
      src_d = SrcMem;
    end else begin
      src_d = SrcIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_d] <= wr_data;
      byp_q       <= wr_data;
    end
    mem_rd_q <= mem[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= IdxW'(NUM_IDS - 1);
      fill_q <= '0;
      src_q  <= SrcIdx;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      src_q  <= src_d;
    end
  end

  always_comb begin
    case (src_q)
      SrcMem:  head_val_o = mem_rd_q;
      SrcByp:  head_val_o = byp_q;
      default: head_val_o = head_q;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ffl_in_use.sv
`timescale 1ns / 1ps
`default_nettype none

module ffl_in_use #(
  parameter int unsigned NUM_ENTRIES = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffl_pkg::map_upd_t           upd_i,
  input  logic [ffl_pkg::IdW-1:0]     rd_id_i,
  output logic                        rd_in_use_o
);

  localparam int unsigned AddrW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [NUM_ENTRIES-1:0] map_q;

  assign rd_in_use_o = (32'(rd_id_i) < NUM_ENTRIES) ? map_q[rd_id_i[AddrW-1:0]] : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else begin
      if (upd_i.set) begin
        map_q[upd_i.set_id[AddrW-1:0]] <= 1'b1;
      end
      if (upd_i.clr) begin
        map_q[upd_i.clr_id[AddrW-1:0]] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/fifo_free_list_id_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// FIFO free-list ID allocator. Each request transaction (allocate, release
// or check) produces exactly one response transaction, and a new request is
// taken in every cycle while the response side keeps up. Each request passes
// through the request register, then the response register. Request ready
// follows response ready combinationally through those two registers. Free
// IDs wait in a ring memory of NUM_IDS entries whose head entry is pre-read
// into a register, with a forward path for an ID released into the slot about
// to be granted; a fill count stands in for the ring's reset contents, so the
// block is ready right after reset with no clearing pass. The allocated marks
// live in flip-flops for the IDs the 8-bit id field can name (at most 256).
module fifo_free_list_id_allocator_core #(
  parameter int unsigned NUM_IDS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffl_req_if.sink           req_i,
  ffl_rsp_if.source         rsp_o
);

  localparam int unsigned IdxW     = $clog2(NUM_IDS);
  localparam int unsigned CntW     = $clog2(NUM_IDS + 1);
  localparam int unsigned MapDepth =
    (NUM_IDS < ffl_pkg::MapMaxDepth) ? NUM_IDS : ffl_pkg::MapMaxDepth;

  // Request register
  logic                          s1_valid_q;
  logic [ffl_pkg::OpW-1:0]       s1_op_q;
  logic [ffl_pkg::IdW-1:0]       s1_id_q;

  // Response register
  logic                          rsp_valid_q;
  logic [ffl_pkg::StatusW-1:0]   rsp_status_q;
  logic [ffl_pkg::AllocIdW-1:0]  rsp_alloc_id_q;
  logic                          rsp_id_free_q;
  logic [ffl_pkg::FreeLeftW-1:0] rsp_free_left_q;

  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          s2_ready;
  logic                          s1_fire;
  logic                          in_range;
  logic                          in_use;
  logic [IdxW-1:0]               head_val;

  ffl_pkg::status_e              status_d;
  logic [ffl_pkg::AllocIdW-1:0]  alloc_id_d;
  logic                          id_free_d;
  ffl_pkg::ring_ctl_t            ring_ctl;
  ffl_pkg::map_upd_t             map_upd;

  // Advance the request register whenever the response register frees up.
  assign s2_ready    = !rsp_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && s2_ready;
  assign req_i.ready = !s1_valid_q || s2_ready;

  assign in_range = 32'(s1_id_q) < NUM_IDS;

  ffl_ring #(
    .NUM_IDS (NUM_IDS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ring_ctl),
    .head_val_o (head_val)
  );

  ffl_in_use #(
    .NUM_ENTRIES (MapDepth)
  ) u_in_use (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (map_upd),
    .rd_id_i     (s1_id_q),
    .rd_in_use_o (in_use)
  );

  // Decode the held request. State changes only on the cycle it moves on.
  always_comb begin
    status_d   = ffl_pkg::StOk;
    alloc_id_d = '0;
    id_free_d  = 1'b0;
    cnt_d      = cnt_q;
    ring_ctl   = '0;
    map_upd    = '0;
    unique case (ffl_pkg::op_e'(s1_op_q))
      ffl_pkg::OpAlloc: begin
        if (cnt_q == '0) begin
          status_d = ffl_pkg::StEmpty;
        end else begin
          alloc_id_d     = ffl_pkg::AllocIdW'(head_val);
          cnt_d          = cnt_q - CntW'(1);
          ring_ctl.pop   = s1_fire;
          // An ID the id field cannot name is never released, so skip its mark.
          map_upd.set    = s1_fire && (32'(head_val) < MapDepth);
          map_upd.set_id = ffl_pkg::IdW'(head_val);
        end
      end
      ffl_pkg::OpRelease: begin
        if (!in_range) begin
          status_d = ffl_pkg::StRange;
        end else if (!in_use) begin
          status_d = ffl_pkg::StNotAlloc;
        end else begin
          cnt_d            = cnt_q + CntW'(1);
          ring_ctl.push    = s1_fire;
          ring_ctl.push_id = s1_id_q;
          map_upd.clr      = s1_fire;
          map_upd.clr_id   = s1_id_q;
        end
      end
      ffl_pkg::OpCheck: begin
        if (!in_range) begin
          status_d = ffl_pkg::StRange;
        end else begin
          id_free_d = !in_use;
        end
      end
      default: begin
        // Unused op code: report the current count and change nothing.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      cnt_q       <= CntW'(NUM_IDS);
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_ready) begin
        rsp_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Payload registers: capture on each transaction, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_op_q <= req_i.op;
      s1_id_q <= req_i.id;
    end
    if (s1_fire) begin
      rsp_status_q    <= status_d;
      rsp_alloc_id_q  <= alloc_id_d;
      rsp_id_free_q   <= id_free_d;
      rsp_free_left_q <= ffl_pkg::FreeLeftW'(cnt_d);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.alloc_id  = rsp_alloc_id_q;
  assign rsp_o.id_free   = rsp_id_free_q;
  assign rsp_o.free_left = rsp_free_left_q;

endmodule

`default_nettype wire

### rtl/core/ffl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ffl_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic [ffl_pkg::StatusW-1:0]   status_i,
  input  logic [ffl_pkg::AllocIdW-1:0]  alloc_id_i,
  input  logic                          id_free_i,
  input  logic [ffl_pkg::FreeLeftW-1:0] free_left_i
);

  logic rsp_stall;
  logic rsp_err;
  logic [ffl_pkg::StatusW+ffl_pkg::AllocIdW+ffl_pkg::FreeLeftW:0] rsp_payload;

  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_err     = rsp_valid_i && (status_i != ffl_pkg::StOk);
  assign rsp_payload = {status_i, alloc_id_i, id_free_i, free_left_i};

  // Hold a stalled response.
  `FFL_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid_i && $stable(rsp_payload))

  // Failed operations grant nothing and report nothing free.
  `FFL_ASSERT(a_err_clean, rsp_err |-> (alloc_id_i == '0) && !id_free_i)

  // Empty is reported only when no ID is left.
  `FFL_ASSERT(a_empty_cnt, rsp_valid_i && (status_i == ffl_pkg::StEmpty) |-> (free_left_i == '0))

  // A check never grants an ID.
  `FFL_ASSERT(a_free_no_grant, rsp_valid_i && id_free_i |-> (alloc_id_i == '0) && !rsp_err)

endmodule

bind fifo_free_list_id_allocator_core ffl_checker u_ffl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .alloc_id_i  (rsp_o.alloc_id),
  .id_free_i   (rsp_o.id_free),
  .free_left_i (rsp_o.free_left)
);

`default_nettype wire
